/* rtl/emt_pkg.sv */
// Shared types and constants for the extent map translation block.
`timescale 1ns / 1ps

package emt_pkg;

	localparam logic CMD_WRITE     = 1'b0;
	localparam logic CMD_TRANSLATE = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_INVALID  = 3'd1;
	localparam logic [2:0] ST_OVERFLOW = 3'd2;
	localparam logic [2:0] ST_RANGE    = 3'd3;
	localparam logic [2:0] ST_NOTFOUND = 3'd4;

	localparam logic REG_BLOCK_SIZE   = 1'b0;
	localparam logic REG_EXTENT_COUNT = 1'b1;

	localparam logic [31:0] BLOCK_SIZE_RESET = 32'd512;

	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = 7;

	typedef struct packed {
		logic        command;
		logic [3:0]  entry_slot;
		logic [63:0] entry_logical;
		logic [63:0] entry_length;
		logic [63:0] entry_block;
		logic [63:0] query_offset;
		logic [63:0] query_length;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] mapped_block;
	} out_item_t;

	typedef struct packed {
		logic [63:0] start;
		logic [63:0] length;
		logic [63:0] block;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quot;
		logic [31:0] rem;
	} div_rsp_t;

endpackage

/* rtl/extent_map_translate_top.sv */
// Top level of the extent map translation block with its register port.
//
//  Channel   Direction  Handshake             Payload
//  in        input      in_valid / in_stall   emt_pkg::in_item_t
//  out       output     out_valid / out_stall emt_pkg::out_item_t
//  config    input      APB psel / penable    block_size, extent_count
//
// A write command passes through the final state into the output register.
// A translate command runs a check step, the offset and length alignment divisions
// on the bit-serial divider and the request-end add, then walks the extents: it loads
// each one, adds its end and compares the offset with both bounds. The matching extent
// gets a range check, the final division and the block add; any error ends it early.
// Reset clears the control state and the extent count and sets the block size to 512; table contents are undefined.
// A result waiting in the output register holds the sequencer only at its final step.
`timescale 1ns / 1ps

module extent_map_translate_top #(
	parameter int MAX_EXTENTS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  emt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output emt_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;

	logic [31:0]       block_size_q;
	logic [4:0]        extent_count_q;
	logic              cfg_wr;
	logic              tbl_wr_en;
	logic [AW-1:0]     tbl_wr_addr;
	emt_pkg::entry_t   tbl_wr_data;
	logic [AW-1:0]     tbl_rd_addr;
	emt_pkg::entry_t   tbl_rd_data;
	emt_pkg::div_req_t div_req;
	emt_pkg::div_rsp_t div_rsp;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q   <= emt_pkg::BLOCK_SIZE_RESET;
			extent_count_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				emt_pkg::REG_BLOCK_SIZE:   block_size_q   <= pwdata;
				emt_pkg::REG_EXTENT_COUNT: extent_count_q <= pwdata[4:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			emt_pkg::REG_BLOCK_SIZE:   prdata = block_size_q;
			emt_pkg::REG_EXTENT_COUNT: prdata = {27'd0, extent_count_q};
			default:                   prdata = '0;
		endcase
	end

	emt_seq #(
		.MAX_EXTENTS(MAX_EXTENTS),
		.AW         (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.block_size  (block_size_q),
		.extent_count(extent_count_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_item     (in_item),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item),
		.tbl_wr_en   (tbl_wr_en),
		.tbl_wr_addr (tbl_wr_addr),
		.tbl_wr_data (tbl_wr_data),
		.tbl_rd_addr (tbl_rd_addr),
		.tbl_rd_data (tbl_rd_data),
		.div_req     (div_req),
		.div_rsp     (div_rsp)
	);

	emt_table #(
		.DEPTH(MAX_EXTENTS),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr_en),
		.wr_addr(tbl_wr_addr),
		.wr_data(tbl_wr_data),
		.rd_addr(tbl_rd_addr),
		.rd_data(tbl_rd_data)
	);

	emt_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block took a second beat while still working");

	a_error_has_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status != emt_pkg::ST_OK |-> out_item.mapped_block == '0)
		else $error("error result carries a nonzero block address");

	a_status_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status == emt_pkg::ST_OK ||
			out_item.status == emt_pkg::ST_INVALID ||
			out_item.status == emt_pkg::ST_OVERFLOW ||
			out_item.status == emt_pkg::ST_RANGE ||
			out_item.status == emt_pkg::ST_NOTFOUND)
		else $error("result status code is out of range");

endmodule

/* rtl/emt_table.sv */
// Extent table memory with one write port and one registered read port.
`timescale 1ns / 1ps

module emt_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  emt_pkg::entry_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output emt_pkg::entry_t rd_data
);

	emt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

/* rtl/emt_div.sv */
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
`timescale 1ns / 1ps

module emt_div (
	input  logic              clk,
	input  logic              arst_n,
	input  emt_pkg::div_req_t req,
	output emt_pkg::div_rsp_t rsp
);

	logic [emt_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;
	logic [63:0]                   quot_q;
	logic [31:0]                   rem_q;
	logic [31:0]                   dvs_q;
	logic [32:0]                   trial;
	logic [33:0]                   diff;
	logic                          ge;

	assign trial = {rem_q, quot_q[63]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = !diff[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= emt_pkg::DIV_CNT_W'(emt_pkg::DIV_STEPS);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == emt_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
			dvs_q  <= req.divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[62:0], ge};
			rem_q  <= ge ? diff[31:0] : trial[31:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/emt_seq.sv */
// Command sequencer with the shared 64-bit adder and the result register.
`timescale 1ns / 1ps

module emt_seq #(
	parameter int MAX_EXTENTS = 16,
	parameter int AW          = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        block_size,
	input  logic [4:0]         extent_count,
	input  logic               in_valid,
	output logic               in_stall,
	input  emt_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output emt_pkg::out_item_t out_item,
	output logic               tbl_wr_en,
	output logic [AW-1:0]      tbl_wr_addr,
	output emt_pkg::entry_t    tbl_wr_data,
	output logic [AW-1:0]      tbl_rd_addr,
	input  emt_pkg::entry_t    tbl_rd_data,
	output emt_pkg::div_req_t  div_req,
	input  emt_pkg::div_rsp_t  div_rsp
);

	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DOFF,
		S_DLEN,
		S_REND,
		S_LOAD,
		S_EEND,
		S_CLO,
		S_CHI,
		S_CRNG,
		S_DDEL,
		S_BASE,
		S_FIN
	} state_t;

	state_t             state_q;
	logic [CMP_W-1:0]   n_q;
	logic [CMP_W-1:0]   idx_q;
	logic [63:0]        off_q;
	logic [63:0]        len_q;
	logic [63:0]        req_end_q;
	logic [63:0]        ext_end_q;
	logic [63:0]        diff_q;
	logic [2:0]         status_q;
	logic [63:0]        blk_q;
	logic               out_valid_q;
	emt_pkg::out_item_t out_q;

	logic               accept;
	logic               slot_ok;
	logic [CMP_W-1:0]   n_lim;
	logic               chk_bad;
	logic               last_entry;
	logic               out_load;
	logic [63:0]        add_a;
	logic [63:0]        add_b;
	logic               add_sub;
	logic [64:0]        add_sum;
	logic               carry;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign slot_ok  = CMP_W'(in_item.entry_slot) < CMP_W'(MAX_EXTENTS);
	assign n_lim    = (CMP_W'(extent_count) > CMP_W'(MAX_EXTENTS)) ?
		CMP_W'(MAX_EXTENTS) : CMP_W'(extent_count);
	assign chk_bad  = (n_q == '0) || (len_q == '0) || (block_size == '0);
	assign last_entry = (idx_q + 1'b1) == n_q;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	assign tbl_wr_en          = accept && (in_item.command == emt_pkg::CMD_WRITE) && slot_ok;
	assign tbl_wr_addr        = AW'(in_item.entry_slot);
	assign tbl_wr_data.start  = in_item.entry_logical;
	assign tbl_wr_data.length = in_item.entry_length;
	assign tbl_wr_data.block  = in_item.entry_block;
	assign tbl_rd_addr        = idx_q[AW-1:0];

	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		case (state_q)
			S_REND: begin
				add_a = off_q;
				add_b = len_q;
			end
			S_EEND: begin
				add_a = tbl_rd_data.start;
				add_b = tbl_rd_data.length;
			end
			S_CLO: begin
				add_a   = off_q;
				add_b   = tbl_rd_data.start;
				add_sub = 1'b1;
			end
			S_CHI: begin
				add_a   = off_q;
				add_b   = ext_end_q;
				add_sub = 1'b1;
			end
			S_CRNG: begin
				add_a   = ext_end_q;
				add_b   = req_end_q;
				add_sub = 1'b1;
			end
			S_BASE: begin
				add_a = tbl_rd_data.block;
				add_b = div_rsp.quot;
			end
			default: begin
				add_a   = '0;
				add_b   = '0;
				add_sub = 1'b0;
			end
		endcase
	end

	assign add_sum = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + 65'(add_sub);
	assign carry   = add_sum[64];

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = off_q;
		div_req.divisor  = block_size;
		if (state_q == S_CHECK && !chk_bad) begin
			div_req.start = 1'b1;
		end else if (state_q == S_DOFF && div_rsp.done && div_rsp.rem == '0) begin
			div_req.start    = 1'b1;
			div_req.dividend = len_q;
		end else if (state_q == S_CRNG && carry) begin
			div_req.start    = 1'b1;
			div_req.dividend = diff_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q        <= 1'b1;
				out_q.status       <= status_q;
				out_q.mapped_block <= blk_q;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= (in_item.command == emt_pkg::CMD_WRITE) ? S_FIN : S_CHECK;
					end
				end
				S_CHECK: state_q <= chk_bad ? S_FIN : S_DOFF;
				S_DOFF: begin
					if (div_rsp.done) begin
						state_q <= (div_rsp.rem != '0) ? S_FIN : S_DLEN;
					end
				end
				S_DLEN: begin
					if (div_rsp.done) begin
						state_q <= (div_rsp.rem != '0) ? S_FIN : S_REND;
					end
				end
				S_REND: state_q <= carry ? S_FIN : S_LOAD;
				S_LOAD: state_q <= S_EEND;
				S_EEND: state_q <= carry ? S_FIN : S_CLO;
				S_CLO: begin
					if (carry) begin
						state_q <= S_CHI;
					end else begin
						state_q <= last_entry ? S_FIN : S_LOAD;
					end
				end
				S_CHI: begin
					if (!carry) begin
						state_q <= S_CRNG;
					end else begin
						state_q <= last_entry ? S_FIN : S_LOAD;
					end
				end
				S_CRNG: state_q <= carry ? S_DDEL : S_FIN;
				S_DDEL: begin
					if (div_rsp.done) begin
						state_q <= S_BASE;
					end
				end
				S_BASE: state_q <= S_FIN;
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					off_q    <= in_item.query_offset;
					len_q    <= in_item.query_length;
					n_q      <= n_lim;
					idx_q    <= '0;
					blk_q    <= '0;
					status_q <= (in_item.command == emt_pkg::CMD_WRITE && !slot_ok) ?
						emt_pkg::ST_INVALID : emt_pkg::ST_OK;
				end
			end
			S_CHECK: begin
				if (chk_bad) begin
					status_q <= emt_pkg::ST_INVALID;
				end
			end
			S_DOFF, S_DLEN: begin
				if (div_rsp.done && div_rsp.rem != '0) begin
					status_q <= emt_pkg::ST_INVALID;
				end
			end
			S_REND: begin
				if (carry) begin
					status_q <= emt_pkg::ST_OVERFLOW;
				end
				req_end_q <= add_sum[63:0];
			end
			S_EEND: begin
				if (carry) begin
					status_q <= emt_pkg::ST_OVERFLOW;
				end
				ext_end_q <= add_sum[63:0];
			end
			S_CLO: begin
				diff_q <= add_sum[63:0];
				if (!carry) begin
					idx_q <= idx_q + 1'b1;
					if (last_entry) begin
						status_q <= emt_pkg::ST_NOTFOUND;
					end
				end
			end
			S_CHI: begin
				if (carry) begin
					idx_q <= idx_q + 1'b1;
					if (last_entry) begin
						status_q <= emt_pkg::ST_NOTFOUND;
					end
				end
			end
			S_CRNG: begin
				if (!carry) begin
					status_q <= emt_pkg::ST_RANGE;
				end
			end
			S_BASE: begin
				if (carry) begin
					status_q <= emt_pkg::ST_OVERFLOW;
				end else begin
					blk_q <= add_sum[63:0];
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

/* tb/tb_extent_map_translate_top.sv */
// Self-checking testbench for the extent map translation block with its own lookup predictor.
`timescale 1ns / 1ps

module tb_extent_map_translate_top;

	localparam int     SLOTS       = 16;
	localparam int     PHASES      = 11;
	localparam int     PHASE_ITEMS = 155;
	localparam longint CYCLE_LIMIT = 64'd4000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	emt_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_stall;
	emt_pkg::out_item_t out_item;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	logic [63:0] map_start [SLOTS];
	logic [63:0] map_len   [SLOTS];
	logic [63:0] map_base  [SLOTS];
	logic [31:0] cfg_block_size;
	logic [4:0]  cfg_extent_count;

	emt_pkg::out_item_t pending_results[$];
	int                 mismatches;
	longint             cycles = 0;
	int                 stall_hold = 0;
	bit                 idle_on;

	extent_map_translate_top #(.MAX_EXTENTS(SLOTS)) u_top (.*);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] bound);
		return (bound == 64'd0) ? 64'd0 : rand64() % bound;
	endfunction

	function automatic int pick_pause();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] layout_unit();
		return (cfg_block_size == 32'd0) ? 64'd512 : {32'd0, cfg_block_size};
	endfunction

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
		end else if (idle_on && $urandom_range(99) < 40) begin
			out_stall <= 1'b1;
			stall_hold = pick_pause() - 1;
		end else begin
			out_stall <= 1'b0;
			stall_hold = $urandom_range(11);
		end
	end

	function automatic emt_pkg::out_item_t predict_lookup(input emt_pkg::in_item_t it);
		emt_pkg::out_item_t res;
		logic [63:0]        bs;
		logic [63:0]        req_end;
		logic [63:0]        ext_end;
		logic [63:0]        delta;
		logic [64:0]        wide;
		int                 n;
		res = '0;
		if (it.command == emt_pkg::CMD_WRITE) begin
			map_start[it.entry_slot] = it.entry_logical;
			map_len[it.entry_slot] = it.entry_length;
			map_base[it.entry_slot] = it.entry_block;
			res.status = emt_pkg::ST_OK;
			return res;
		end
		bs = {32'd0, cfg_block_size};
		n = (cfg_extent_count > SLOTS) ? SLOTS : cfg_extent_count;
		res.status = emt_pkg::ST_INVALID;
		if (n == 0 || it.query_length == 64'd0 || bs == 64'd0)
			return res;
		if (it.query_offset % bs != 64'd0 || it.query_length % bs != 64'd0)
			return res;
		wide = {1'b0, it.query_offset} + {1'b0, it.query_length};
		res.status = emt_pkg::ST_OVERFLOW;
		if (wide[64])
			return res;
		req_end = wide[63:0];
		for (int i = 0; i < n; i++) begin
			wide = {1'b0, map_start[i]} + {1'b0, map_len[i]};
			if (wide[64]) begin
				res.status = emt_pkg::ST_OVERFLOW;
				return res;
			end
			ext_end = wide[63:0];
			if (it.query_offset < map_start[i] || it.query_offset >= ext_end)
				continue;
			if (req_end > ext_end) begin
				res.status = emt_pkg::ST_RANGE;
				return res;
			end
			delta = (it.query_offset - map_start[i]) / bs;
			wide = {1'b0, map_base[i]} + {1'b0, delta};
			if (wide[64]) begin
				res.status = emt_pkg::ST_OVERFLOW;
				return res;
			end
			res.status = emt_pkg::ST_OK;
			res.mapped_block = wide[63:0];
			return res;
		end
		res.status = emt_pkg::ST_NOTFOUND;
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_results
		emt_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected beat: status %0d block %h",
					out_item.status, out_item.mapped_block));
			end else begin
				want = pending_results.pop_front();
				if (out_item.status !== want.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						out_item.status, want.status));
				if (out_item.mapped_block !== want.mapped_block)
					report_mismatch($sformatf("mapped_block %h, expected %h",
						out_item.mapped_block, want.mapped_block));
			end
		end
	end

	task automatic send_item(input emt_pkg::in_item_t it);
		int gap;
		if (idle_on && $urandom_range(1) == 1)
			gap = pick_pause();
		else
			gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(predict_lookup(it));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic sel, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (sel == emt_pkg::REG_BLOCK_SIZE)
			cfg_block_size = value;
		else
			cfg_extent_count = value[4:0];
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] bs, input logic [4:0] count);
		drain_results();
		write_reg(emt_pkg::REG_BLOCK_SIZE, bs);
		write_reg(emt_pkg::REG_EXTENT_COUNT, {27'd0, count});
	endtask

	function automatic emt_pkg::in_item_t noise_item();
		emt_pkg::in_item_t it;
		it.command = 1'($urandom_range(1));
		it.entry_slot = 4'($urandom_range(SLOTS - 1));
		it.entry_logical = rand64();
		it.entry_length = rand64();
		it.entry_block = rand64();
		it.query_offset = rand64();
		it.query_length = rand64();
		return it;
	endfunction

	task automatic translate_req(input logic [63:0] offset, input logic [63:0] length);
		emt_pkg::in_item_t it;
		it = noise_item();
		it.command = emt_pkg::CMD_TRANSLATE;
		it.query_offset = offset;
		it.query_length = length;
		send_item(it);
	endtask

	task automatic write_extent(input logic [3:0] slot, input logic [63:0] start,
			input logic [63:0] length, input logic [63:0] base);
		emt_pkg::in_item_t it;
		it = noise_item();
		it.command = emt_pkg::CMD_WRITE;
		it.entry_slot = slot;
		it.entry_logical = start;
		it.entry_length = length;
		it.entry_block = base;
		send_item(it);
	endtask

	// Contiguous aligned extents with an occasional hole between neighbors.
	task automatic load_extents();
		logic [63:0] bs;
		logic [63:0] cursor;
		logic [63:0] length;
		bs = layout_unit();
		cursor = rand_below(64'd1 << 20) * bs;
		for (int s = 0; s < SLOTS; s++) begin
			length = 64'($urandom_range(1, 8)) * bs;
			write_extent(4'(s), cursor, length, rand_below(64'd1 << 48));
			cursor = cursor + length + (($urandom_range(3) == 0) ? bs : 64'd0);
		end
	endtask

	function automatic emt_pkg::in_item_t make_query();
		emt_pkg::in_item_t it;
		logic [63:0]       bs;
		logic [63:0]       blocks;
		logic [63:0]       k;
		logic [63:0]       m;
		int                n;
		int                i;
		int                pick;
		it = noise_item();
		it.command = emt_pkg::CMD_TRANSLATE;
		bs = layout_unit();
		n = (cfg_extent_count > SLOTS) ? SLOTS : cfg_extent_count;
		if (n == 0)
			n = 1;
		i = $urandom_range(n - 1);
		blocks = map_len[i] / bs;
		pick = $urandom_range(99);
		if (pick < 60 && blocks != 64'd0) begin
			k = rand_below(blocks);
			m = blocks - k;
			if ($urandom_range(9) == 0)
				m = m + 64'($urandom_range(1, 3));
			else
				m = 64'd1 + rand_below(m);
			it.query_offset = map_start[i] + k * bs;
			it.query_length = m * bs;
		end else if (pick < 68) begin
			it.query_offset = map_start[n - 1] + map_len[n - 1] + rand_below(64'd16) * bs;
			it.query_length = (rand_below(64'd4) + 64'd1) * bs;
		end else if (pick < 76) begin
			it.query_offset = map_start[i] + (($urandom_range(1) == 1) ? 64'd0 :
				64'd1 + rand_below(bs - 64'd1));
			it.query_length = bs + (($urandom_range(1) == 1) ? 64'd1 : 64'd0);
		end else if (pick < 80) begin
			it.query_offset = map_start[i];
			it.query_length = 64'd0;
		end else if (pick < 86) begin
			it.query_offset = ((~64'd0) / bs - rand_below(64'd4)) * bs;
			it.query_length = (rand_below(64'd16) + 64'd1) * bs;
		end else if (pick < 93) begin
			it.query_offset = rand64() / bs * bs;
			it.query_length = (rand_below(64'd64) + 64'd1) * bs;
		end
		return it;
	endfunction

	function automatic emt_pkg::in_item_t make_update();
		emt_pkg::in_item_t it;
		logic [63:0]       bs;
		int                s;
		it = noise_item();
		it.command = emt_pkg::CMD_WRITE;
		s = $urandom_range(SLOTS - 1);
		it.entry_slot = 4'(s);
		bs = layout_unit();
		case ($urandom_range(49))
			0: ;
			1, 2, 3: begin
				it.entry_logical = map_start[s];
				it.entry_length = map_len[s] + bs;
			end
			4, 5: begin
				it.entry_logical = map_start[s];
				it.entry_length = map_len[s] - bs;
			end
			6, 7, 8: begin
				it.entry_logical = map_start[s];
				it.entry_length = map_len[s];
				it.entry_block = ~64'd0 - rand_below(64'd8);
			end
			default: begin
				it.entry_logical = map_start[s];
				it.entry_length = map_len[s];
				if ($urandom_range(3) != 0)
					it.entry_block = rand_below(64'd1 << 48);
			end
		endcase
		return it;
	endfunction

	task automatic test_count_zero();
		translate_req(64'd0, 64'd512);
		translate_req(rand64(), rand64());
	endtask

	task automatic test_directed_lookup();
		logic [63:0] past_end;
		load_extents();
		set_config(32'd512, 5'd16);
		past_end = map_start[15] + map_len[15];
		translate_req(map_start[0], 64'd512);
		translate_req(past_end - 64'd512, 64'd512);
		translate_req(map_start[3], map_len[3]);
		translate_req(map_start[3], map_len[3] + 64'd512);
		translate_req(map_start[3] + 64'd1, 64'd512);
		translate_req(map_start[3], 64'd513);
		translate_req(map_start[3], 64'd0);
		translate_req(past_end + 64'd8192, 64'd512);
		translate_req(~64'd511, 64'd1024);
		translate_req(64'd0, ~64'd511);
		// An earlier slot that overlaps a later one wins the walk.
		write_extent(4'd1, map_start[4], map_len[4], 64'h1234_0000);
		translate_req(map_start[4], 64'd512);
	endtask

	task automatic test_wrap_cases();
		logic [63:0] s14, l14, b14, s15, l15, b15;
		s14 = map_start[14];
		l14 = map_len[14];
		b14 = map_base[14];
		s15 = map_start[15];
		l15 = map_len[15];
		b15 = map_base[15];
		write_extent(4'd15, s15, 64'd1024, ~64'd0);
		translate_req(s15, 64'd512);
		translate_req(s15 + 64'd512, 64'd512);
		write_extent(4'd15, ~64'd1023, 64'd1024, 64'd0);
		translate_req(~64'd1023, 64'd512);
		translate_req(map_start[0], 64'd512);
		write_extent(4'd14, ~64'd0, ~64'd0, ~64'd0);
		translate_req(64'd0, 64'd512);
		write_extent(4'd14, s14, l14, b14);
		write_extent(4'd15, s15, l15, b15);
	endtask

	task automatic test_register_extremes();
		set_config(32'd0, 5'd16);
		translate_req(map_start[2], 64'd512);
		set_config(32'd1, 5'd16);
		translate_req(map_start[2] + 64'd7, 64'd3);
		set_config(32'hFFFF_FFFF, 5'd16);
		translate_req(64'd0, 64'hFFFF_FFFF);
		set_config(32'd512, 5'd1);
		translate_req(map_start[5], 64'd512);
		translate_req(map_start[0], 64'd512);
	endtask

	task automatic test_random_traffic();
		logic [31:0] sizes [PHASES] = '{32'd512, 32'd1, 32'd4096, 32'hFFFF_FFFF, 32'd3,
			32'd0, 32'h8000_0000, 32'd0, 32'd65536, 32'd7, 32'd512};
		logic [4:0] counts [PHASES] = '{5'd16, 5'd16, 5'd8, 5'd16, 5'd5, 5'd16, 5'd1,
			5'd12, 5'd20, 5'd16, 5'd3};
		logic [31:0] bs;
		for (int p = 0; p < PHASES; p++) begin
			bs = (p == 7) ? $urandom() : sizes[p];
			set_config(bs, counts[p]);
			idle_on = (p % 3 != 1);
			load_extents();
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(3) == 0)
					send_item(make_update());
				else
					send_item(make_query());
				if ($urandom_range(60) == 0)
					drain_results();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		idle_on = 1'b1;
		mismatches = 0;
		cfg_block_size = emt_pkg::BLOCK_SIZE_RESET;
		cfg_extent_count = 5'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_count_zero();
		test_directed_lookup();
		test_wrap_cases();
		test_register_extremes();
		test_random_traffic();
		drain_results();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/emt_pkg.sv
rtl/emt_table.sv
rtl/emt_div.sv
rtl/emt_seq.sv
rtl/extent_map_translate_top.sv
tb/tb_extent_map_translate_top.sv
